/* sv/pbso_pkg.sv */
// shared types and constants of the progressive block scan order generator
`default_nettype none

package pbso_pkg;

    // largest frame side in pixels
    localparam int MAX_DIM = 4096;

    // port widths of the word fields
    localparam int COORD_W = 12;
    localparam int SIZE_W  = 13;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    // frame size after reset
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [SIZE_W-1:0]  size_t;
    typedef logic [CFG_W-1:0]   cfg_t;

    // one result word
    typedef struct packed {
        coord_t block_x;
        coord_t block_y;
        size_t  block_size;
        size_t  fill_width;
        size_t  fill_height;
        logic   frame_done;
    } result_t;

endpackage

`default_nettype wire

/* sv/progressive_block_scan_order.sv */
// progressive block scan order generator, top level
//
// Each request word returns the next square block of a coarse-to-fine
// progressive scan over a frame of frame_width x frame_height pixels: the
// block corner, its size and its size clipped at the right and bottom frame
// edges, with frame_done set on the last block of the frame. The first pass
// uses one block whose side is the smallest power of two not below the larger
// dimension; each later pass halves the side and emits only the blocks the
// earlier passes have not covered. restart makes the request taken with it
// start a new frame; a register write or the end of a frame makes the next
// request start one. Throughput is one word per clock while in_stall is low:
// the next scan position is found in the same cycle as the request by a few
// adds and compares (at most two row candidates and one pass step), and the
// result goes to an output register backed by a one-word skid stage, so a
// request is taken even while a result waits at the output, until the skid
// stage is full. A register write also precomputes the clamped dimensions
// and first block size; zero is used as one and above MAX_DIM as MAX_DIM.
`default_nettype none

module progressive_block_scan_order (
    input  wire                                clk,
    input  wire                                rst_n,
    // configuration write port
    input  wire                                cfg_write,
    input  wire  [pbso_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [pbso_pkg::CFG_W-1:0]         cfg_data,
    // request channel
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire                                restart,
    // result channel
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic [pbso_pkg::COORD_W-1:0]       block_x,
    output logic [pbso_pkg::COORD_W-1:0]       block_y,
    output logic [pbso_pkg::SIZE_W-1:0]        block_size,
    output logic [pbso_pkg::SIZE_W-1:0]        fill_width,
    output logic [pbso_pkg::SIZE_W-1:0]        fill_height,
    output logic                               frame_done
);

    // internal width: holds the first block size and sums up to x + 2 * size
    localparam int DW = $clog2(pbso_pkg::MAX_DIM) + 2;

    typedef logic [DW-1:0] dim_t;

    // clamp a register value to 1 .. MAX_DIM
    function automatic dim_t clamp_dim(input pbso_pkg::cfg_t v);
        dim_t r;
        if (v == '0)
        begin
            r = dim_t'(1);
        end
        else if (32'(v) > 32'(pbso_pkg::MAX_DIM))
        begin
            r = dim_t'(pbso_pkg::MAX_DIM);
        end
        else
        begin
            r = dim_t'(v);
        end
        return r;
    endfunction

    // smallest power of two not below the larger dimension
    function automatic dim_t first_size(input dim_t a, input dim_t b);
        dim_t m;
        dim_t v;
        m = (a > b) ? a : b;
        v = m - dim_t'(1);
        for (int i = 1; i < DW; i = i * 2)
        begin
            v = v | (v >> i);
        end
        return v + dim_t'(1);
    endfunction

    localparam dim_t RST_W  = clamp_dim(pbso_pkg::cfg_t'(pbso_pkg::RESET_WIDTH));
    localparam dim_t RST_H  = clamp_dim(pbso_pkg::cfg_t'(pbso_pkg::RESET_HEIGHT));
    localparam dim_t RST_S0 = first_size(RST_W, RST_H);

    // clamped frame size and first block size, updated on register writes
    dim_t w_reg;
    dim_t h_reg;
    dim_t s0_reg;

    // scan position of the block to return next
    dim_t x_reg, x_next;
    dim_t y_reg, y_next;
    dim_t s_reg, s_next;
    logic pending_reg, pending_next;

    // output register and skid stage
    pbso_pkg::result_t out_reg;
    pbso_pkg::result_t skid_reg;
    logic              out_valid_reg;
    logic              skid_full_reg;
    pbso_pkg::result_t res;

    logic accept;
    logic out_fire;

    // current block after a possible frame start
    logic start;
    dim_t cx, cy, cs;
    dim_t rem_w, rem_h;
    dim_t fw, fh;

    // candidates for the next block
    logic row0_all, row1_all;
    dim_t nx, ny1, ny2, fx1, hs;
    logic done;

    assign accept   = in_valid && !skid_full_reg;
    assign out_fire = out_valid_reg && !out_stall;
    assign in_stall = skid_full_reg;

    always_comb
    begin
        start = restart || pending_reg;
        cx = start ? '0 : x_reg;
        cy = start ? '0 : y_reg;
        cs = start ? s0_reg : s_reg;

        // clip at the frame edges, corner is always inside the frame
        rem_w = w_reg - cx;
        rem_h = h_reg - cy;
        fw = (rem_w < cs) ? rem_w : cs;
        fh = (rem_h < cs) ? rem_h : cs;

        // odd rows of a pass (and every row of the first pass) emit every block
        row0_all = (cs == s0_reg) || ((cy & cs) != '0);
        nx  = cx + (row0_all ? cs : (cs << 1));
        ny1 = cy + cs;
        ny2 = cy + (cs << 1);
        row1_all = (cs == s0_reg) || ((ny1 & cs) != '0);
        fx1 = row1_all ? '0 : cs;
        hs  = cs >> 1;

        done         = 1'b0;
        x_next       = '0;
        y_next       = '0;
        s_next       = cs;
        pending_next = 1'b0;
        if (nx < w_reg)
        begin
            // next block on the same row
            x_next = nx;
            y_next = cy;
        end
        else if ((ny1 < h_reg) && (fx1 < w_reg))
        begin
            x_next = fx1;
            y_next = ny1;
        end
        else if (ny2 < h_reg)
        begin
            // even row had no block, the odd row after it starts at column 0
            x_next = '0;
            y_next = ny2;
        end
        else if (hs != '0)
        begin
            // next pass always has a block at row 0 or at column 0
            s_next = hs;
            if (hs < w_reg)
            begin
                x_next = hs;
            end
            else
            begin
                y_next = hs;
            end
        end
        else
        begin
            done         = 1'b1;
            s_next       = '0;
            pending_next = 1'b1;
        end

        res.block_x     = pbso_pkg::coord_t'(cx);
        res.block_y     = pbso_pkg::coord_t'(cy);
        res.block_size  = pbso_pkg::size_t'(cs);
        res.fill_width  = pbso_pkg::size_t'(fw);
        res.fill_height = pbso_pkg::size_t'(fh);
        res.frame_done  = done;
    end

    // frame size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg  <= RST_W;
            h_reg  <= RST_H;
            s0_reg <= RST_S0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pbso_pkg::CFG_FRAME_WIDTH:
                begin
                    w_reg  <= clamp_dim(cfg_data);
                    s0_reg <= first_size(clamp_dim(cfg_data), h_reg);
                end
                pbso_pkg::CFG_FRAME_HEIGHT:
                begin
                    h_reg  <= clamp_dim(cfg_data);
                    s0_reg <= first_size(w_reg, clamp_dim(cfg_data));
                end
                default:
                begin
                    w_reg <= w_reg;
                end
            endcase
        end
    end

    // scan state; any register write starts a new frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg       <= '0;
            y_reg       <= '0;
            s_reg       <= '0;
            pending_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            pending_reg <= 1'b1;
        end
        else if (accept)
        begin
            x_reg       <= x_next;
            y_reg       <= y_next;
            s_reg       <= s_next;
            pending_reg <= pending_next;
        end
    end

    // output register with a one-word skid stage behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (skid_full_reg)
            begin
                out_valid_reg <= 1'b1;
                skid_full_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            if (skid_full_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (accept)
            begin
                out_reg <= res;
            end
        end
        else if (accept)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign block_x     = out_reg.block_x;
    assign block_y     = out_reg.block_y;
    assign block_size  = out_reg.block_size;
    assign fill_width  = out_reg.fill_width;
    assign fill_height = out_reg.fill_height;
    assign frame_done  = out_reg.frame_done;

    // skid word only exists behind a held output word
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid word without output word");

    // inside a frame the pass size is a nonzero power of two
    a_pass_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        !pending_reg |-> (s_reg != '0) && ((s_reg & (s_reg - dim_t'(1))) == '0))
        else $error("pass size not a power of two");

    // inside a frame the pass size never exceeds the first size
    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !pending_reg |-> (s_reg <= s0_reg))
        else $error("pass size above first block size");

    // the next block corner lies inside the frame
    a_corner_inside: assert property (@(posedge clk) disable iff (!rst_n)
        !pending_reg |-> (x_reg < w_reg) && (y_reg < h_reg))
        else $error("next block corner outside the frame");

endmodule

`default_nettype wire
